@@ hdl/modexp_pkg.sv @@
// Shared constants and types for the modular exponentiation block.
package modexp_pkg;

  // Width of the dividend that the bit-serial reducer walks through, MSB first.
  localparam int DIV_BITS = 64;
  localparam int CNT_W    = $clog2(DIV_BITS);

  localparam logic [31:0] MODULUS_RESET = 32'd1000000007;

  // Which register receives the remainder when a reduction pass ends.
  typedef enum logic [1:0] {
    T_BASE,
    T_ACC,
    T_SQR
  } tgt_t;

endpackage

@@ hdl/modular_exponentiation.sv @@
// Modular exponentiation by right-to-left square-and-multiply with a shared reducer.
//
// Usage: write the modulus on the cfg channel (cfg_data, always ready) while the
// block is idle; it resets to 1000000007, and a modulus of zero acts as
// 2^MODULUS_BITS. Each input item on s_* carries a base and an exponent and
// yields one item on m_*: base^exponent mod modulus, or 1 for a zero exponent.
// One multiplier (MODULUS_BITS square) feeds a restoring remainder unit that
// retires one dividend bit per cycle. An item first reduces the base, then for
// each exponent bit up to the highest set one runs a step, a multiply and
// reduction of the accumulator when the bit is set, and a square and reduction
// of the base; a final state then writes the result. With a zero modulus no
// reduction pass runs and products are simply truncated to MODULUS_BITS.
// The block takes one item at a time: s_tready is high only while idle.
// A finished result sits in the output register; if the receiver stalls, the
// block may still accept the next item and only holds before writing its own
// result. Reset is synchronous and returns the sequencer to idle, drops
// m_tvalid and restores the default modulus.
module modular_exponentiation
  import modexp_pkg::*;
#(
  parameter int MODULUS_BITS  = 32,
  parameter int EXPONENT_BITS = 63
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [31:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // [62:0] base_value, [125:63] exponent, [127:126] zero
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [31:0]  m_tdata    // [31:0] power_result
);

  localparam int M = MODULUS_BITS;
  localparam int E = EXPONENT_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_STEP,
    S_SQR,
    S_DIV,
    S_DONE
  } state_t;

  state_t                state;
  tgt_t                  target;
  logic [M-1:0]          modulus;
  logic [M-1:0]          acc;
  logic [M-1:0]          b;
  logic [E-1:0]          expo;
  logic [DIV_BITS-1:0]   dividend;
  logic [M-1:0]          rem;
  logic [CNT_W-1:0]      cnt;

  logic                  mod_zero;
  logic [M-1:0]          op_a;
  logic [2*M-1:0]        prod;
  logic [M:0]            trial;
  logic [M-1:0]          rem_next;
  logic                  div_last;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign mod_zero  = (modulus == '0);

  // The one multiplier: acc * b for a set exponent bit, b * b for the square.
  assign op_a = (state == S_STEP) ? acc : b;
  assign prod = op_a * b;

  // Restoring remainder step; the partial remainder always stays below the modulus.
  always_comb begin
    trial = {rem, dividend[DIV_BITS-1]};
    if (trial >= {1'b0, modulus}) begin
      rem_next = M'(trial - {1'b0, modulus});
    end else begin
      rem_next = trial[M-1:0];
    end
  end

  assign div_last = (cnt == CNT_W'(DIV_BITS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      modulus  <= MODULUS_RESET[M-1:0];
    end else begin
      if (cfg_valid) begin
        modulus <= cfg_data[M-1:0];
      end
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            acc  <= M'(1);
            expo <= s_tdata[63 +: E];
            if (mod_zero) begin
              b     <= s_tdata[M-1:0];
              state <= S_STEP;
            end else begin
              dividend <= {1'b0, s_tdata[62:0]};
              rem      <= '0;
              cnt      <= '0;
              target   <= T_BASE;
              state    <= S_DIV;
            end
          end
        end
        S_STEP: begin
          if (expo == '0) begin
            state <= S_DONE;
          end else if (expo[0]) begin
            if (mod_zero) begin
              acc   <= prod[M-1:0];
              state <= S_SQR;
            end else begin
              dividend <= DIV_BITS'(prod);
              rem      <= '0;
              cnt      <= '0;
              target   <= T_ACC;
              state    <= S_DIV;
            end
          end else begin
            state <= S_SQR;
          end
        end
        S_SQR: begin
          if (mod_zero) begin
            b     <= prod[M-1:0];
            expo  <= expo >> 1;
            state <= S_STEP;
          end else begin
            dividend <= DIV_BITS'(prod);
            rem      <= '0;
            cnt      <= '0;
            target   <= T_SQR;
            state    <= S_DIV;
          end
        end
        S_DIV: begin
          dividend <= dividend << 1;
          rem      <= rem_next;
          cnt      <= cnt + CNT_W'(1);
          if (div_last) begin
            case (target)
              T_BASE: begin
                b     <= rem_next;
                state <= S_STEP;
              end
              T_ACC: begin
                acc   <= rem_next;
                state <= S_SQR;
              end
              T_SQR: begin
                b     <= rem_next;
                expo  <= expo >> 1;
                state <= S_STEP;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= 32'(acc);
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // An accepted item always starts the sequencer.
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state != S_IDLE))
    else $error("accepted item did not start the sequencer");

  // The serial reducer only runs for a nonzero modulus.
  a_div_mod_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> !mod_zero)
    else $error("reduction pass with zero modulus");

  // The running base is always fully reduced between steps.
  a_base_reduced: assert property (@(posedge clk) disable iff (rst)
    (state == S_STEP && !mod_zero) |-> (b < modulus))
    else $error("base not reduced below modulus");

  // A finished item with a free output register is delivered and the block idles.
  a_done_delivers: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && (!m_tvalid || m_tready)) |=> (m_tvalid && state == S_IDLE))
    else $error("finished item not delivered");
`endif

endmodule

@@ verif/modular_exponentiation_tb.sv @@
// Self-checking testbench for the modular exponentiation block.
module modular_exponentiation_tb;
  import modexp_pkg::*;

  localparam int CYCLE_LIMIT = 6000000;
  localparam int STALL_CYCLES = 20000;
  localparam logic [62:0] ALL_ONES_63 = '1;

  // Holds the expected powers in arrival order and checks each result against them.
  class power_scoreboard;
    logic [31:0] modulus;
    logic [31:0] expected_powers[$];
    int unsigned mismatches;

    function new();
      modulus = MODULUS_RESET;
      mismatches = 0;
    endfunction

    // A zero modulus stands for 2^32, so the reduction is a plain mask.
    function logic [63:0] reduce(logic [63:0] x);
      if (modulus == 32'd0) return x & 64'hFFFF_FFFF;
      return x % {32'd0, modulus};
    endfunction

    function logic [31:0] predict_power(logic [62:0] base_value, logic [62:0] exponent);
      logic [63:0] acc;
      logic [63:0] sq;
      logic [62:0] rest;
      acc = 64'd1;
      sq = reduce({1'b0, base_value});
      rest = exponent;
      while (rest != '0) begin
        if (rest[0]) acc = reduce(acc * sq);
        sq = reduce(sq * sq);
        rest = rest >> 1;
      end
      return acc[31:0];
    endfunction

    function void note_item(logic [62:0] base_value, logic [62:0] exponent);
      expected_powers = {expected_powers, predict_power(base_value, exponent)};
    endfunction

    function void check_result(logic [31:0] power_result);
      logic [31:0] want;
      if (expected_powers.size() == 0) begin
        $error("power_result: expected nothing, actual %0d", power_result);
        mismatches++;
        return;
      end
      want = expected_powers.pop_front();
      if (power_result !== want) begin
        $error("power_result: expected %0d, actual %0d", want, power_result);
        mismatches++;
      end
    endfunction

    function int outstanding();
      return expected_powers.size();
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [31:0]  cfg_data;
  logic         s_tvalid;
  logic         s_tready;
  logic [127:0] s_tdata;   // [62:0] base_value, [125:63] exponent, [127:126] zero
  logic         m_tvalid;
  logic         m_tready;
  logic [31:0]  m_tdata;   // [31:0] power_result

  power_scoreboard sb = new();
  logic calm = 1'b0;
  logic hold_req = 1'b0;
  int unsigned cycle_count = 0;

  modular_exponentiation dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("modular_exponentiation_tb: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    bit held;
    held = 1'b0;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req && !held) begin
        m_tready <= 1'b0;
        held = 1'b1;
        repeat (STALL_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  function automatic logic [62:0] rand_base();
    logic [63:0] r;
    r = {$urandom, $urandom};
    if ($urandom_range(0, 4) == 0) return {31'd0, r[31:0]};
    return r[62:0];
  endfunction

  // Mostly short exponents, with an occasional full-width or zero one.
  function automatic logic [62:0] rand_exponent();
    logic [63:0] r;
    int unsigned w;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 19))
      0: return r[62:0];
      1: return '0;
      default: begin
        w = $urandom_range(1, 12);
        return r[62:0] & ((63'd1 << w) - 63'd1);
      end
    endcase
  endfunction

  task automatic send_item(input logic [62:0] base_value, input logic [62:0] exponent);
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, exponent, base_value};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_item(base_value, exponent);
  endtask

  task automatic send_random_item(input bit gaps);
    if (gaps && !calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    send_item(rand_base(), rand_exponent());
  endtask

  // Modulus changes only once every expected result is back.
  task automatic set_modulus(input logic [31:0] value);
    s_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.modulus = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(input logic [31:0] value, input int count);
    set_modulus(value);
    repeat (count) send_random_item(1'b1);
  endtask

  initial begin
    rst       <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Default modulus straight out of reset.
    send_item(63'd0, 63'd0);
    send_item(63'd0, 63'd5);
    send_item(ALL_ONES_63, 63'd1);
    send_item(63'd2, 63'd10);
    send_item(63'd1000000007, 63'd3);
    send_item(ALL_ONES_63, ALL_ONES_63);
    send_item(rand_base(), 63'd0);

    // A modulus of one still gives one for a zero exponent.
    set_modulus(32'd1);
    send_item(63'd5, 63'd0);
    send_item(63'd5, 63'd7);
    send_item(63'd12345, 63'd9);

    // Zero modulus wraps at 2^32.
    set_modulus(32'd0);
    send_item(ALL_ONES_63, ALL_ONES_63);
    send_item(63'd3, 63'd40);
    send_item(63'd2, 63'd32);
    send_item(63'd2, 63'd31);

    set_modulus(32'hFFFF_FFFF);
    send_item(ALL_ONES_63, ALL_ONES_63);
    send_item(63'hFFFF_FFFE, 63'd2);

    set_modulus(32'd2);
    send_item(63'd7, 63'd123);
    send_item(63'd4, 63'd1);

    random_phase($urandom | 32'h8000_0000, 24);

    // Long receiver hold-off while items keep coming, so the input side backs up.
    set_modulus($urandom_range(2, 1000));
    hold_req <= 1'b1;
    repeat (6) send_random_item(1'b0);
    repeat (18) send_random_item(1'b1);

    random_phase(32'd0, 16);
    random_phase(32'hFFFF_FFFF, 16);
    random_phase(32'd1, 12);
    random_phase($urandom, 12);

    set_modulus($urandom);
    calm = 1'b1;
    repeat (24) send_random_item(1'b1);

    s_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("modular_exponentiation_tb: done, clean");
    end else begin
      $display("modular_exponentiation_tb: done, errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/modexp_pkg.sv
hdl/modular_exponentiation.sv
verif/modular_exponentiation_tb.sv
